// File: sv/pcd_pkg.sv
package pcd_pkg;

   // Character codes of the move command
   localparam logic [7:0] CHAR_ZERO  = 8'd48;
   localparam logic [7:0] CHAR_TWO   = 8'h32;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_C     = 8'h43;
   localparam logic [7:0] CHAR_COMMA = 8'h2C;

   // Fixed command words, first character in the top byte
   localparam logic [63:0] WORD_GOTOHOME = "GOTOHOME";
   localparam logic [63:0] WORD_STCTOUCH = "STCTOUCH";
   localparam logic [63:0] WORD_MAKEATAP = "MAKEATAP";
   localparam logic [63:0] WORD_TAKELIFT = "TAKELIFT";

   localparam int unsigned COORD_W     = 9;
   localparam int unsigned QUEUE_DEPTH = 2;
   localparam int unsigned QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [2:0] {
      KIND_MOVE,
      KIND_BAD_COORD,
      KIND_HOME,
      KIND_TOUCH,
      KIND_TAP,
      KIND_LIFT,
      KIND_UNKNOWN
   } kind_type;

   typedef enum logic [1:0] {
      STATUS_DONE      = 2'd0,
      STATUS_BAD_COORD = 2'd1,
      STATUS_UNKNOWN   = 2'd2
   } status_type;

   typedef logic [COORD_W-1:0] coord_type;

   // Classified command passed from front to back
   typedef struct packed {
      kind_type  kind;
      coord_type new_x;
      coord_type new_y;
   } cmd_type;

endpackage

// File: sv/pcd_req_if.sv
interface pcd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char0;
   logic [7:0] char1;
   logic [7:0] char2;
   logic [7:0] char3;
   logic [7:0] char4;
   logic [7:0] char5;
   logic [7:0] char6;
   logic [7:0] char7;

   modport source (
      output valid, char0, char1, char2, char3, char4, char5, char6, char7,
      input  ready
   );
   modport sink (
      input  valid, char0, char1, char2, char3, char4, char5, char6, char7,
      output ready
   );
endinterface

// File: sv/pcd_rsp_if.sv
interface pcd_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] status;
   logic       x_increasing;
   logic [8:0] x_steps;
   logic       y_increasing;
   logic [8:0] y_steps;
   logic       pen_down;
   logic       tap_request;
   logic       home_request;

   modport source (
      output valid, status, x_increasing, x_steps, y_increasing, y_steps,
             pen_down, tap_request, home_request,
      input  ready
   );
   modport sink (
      input  valid, status, x_increasing, x_steps, y_increasing, y_steps,
             pen_down, tap_request, home_request,
      output ready
   );
endinterface

// File: sv/pcd_front.sv
module pcd_front (
   pcd_req_if.sink          req_chan,
   input  logic             queue_ready,
   output logic             queue_push,
   output pcd_pkg::cmd_type queue_cmd
);

   logic [63:0] word;
   logic        x_ok;
   logic        y_ok;

   function automatic logic digit_ok(input logic [7:0] c, input logic [7:0] hi);
      return (c >= pcd_pkg::CHAR_ZERO) && (c <= hi);
   endfunction

   function automatic pcd_pkg::coord_type to_coord(input logic [7:0] h,
                                                   input logic [7:0] t,
                                                   input logic [7:0] u);
      return pcd_pkg::COORD_W'(h[3:0]) * pcd_pkg::COORD_W'(100)
           + pcd_pkg::COORD_W'(t[3:0]) * pcd_pkg::COORD_W'(10)
           + pcd_pkg::COORD_W'(u[3:0]);
   endfunction

   assign word = {req_chan.char0, req_chan.char1, req_chan.char2, req_chan.char3,
                  req_chan.char4, req_chan.char5, req_chan.char6, req_chan.char7};

   // Check coordinate digits
   assign x_ok = digit_ok(req_chan.char1, pcd_pkg::CHAR_TWO)
              && digit_ok(req_chan.char2, pcd_pkg::CHAR_NINE)
              && digit_ok(req_chan.char3, pcd_pkg::CHAR_NINE);
   assign y_ok = digit_ok(req_chan.char5, pcd_pkg::CHAR_TWO)
              && digit_ok(req_chan.char6, pcd_pkg::CHAR_NINE)
              && digit_ok(req_chan.char7, pcd_pkg::CHAR_NINE);

   // Classify the command
   always_comb begin
      queue_cmd.new_x = to_coord(req_chan.char1, req_chan.char2, req_chan.char3);
      queue_cmd.new_y = to_coord(req_chan.char5, req_chan.char6, req_chan.char7);
      priority if (req_chan.char0 == pcd_pkg::CHAR_C) begin
         if (x_ok && y_ok && (req_chan.char4 == pcd_pkg::CHAR_COMMA)) begin
            queue_cmd.kind = pcd_pkg::KIND_MOVE;
         end else begin
            queue_cmd.kind = pcd_pkg::KIND_BAD_COORD;
         end
      end else if (word == pcd_pkg::WORD_GOTOHOME) begin
         queue_cmd.kind = pcd_pkg::KIND_HOME;
      end else if (word == pcd_pkg::WORD_STCTOUCH) begin
         queue_cmd.kind = pcd_pkg::KIND_TOUCH;
      end else if (word == pcd_pkg::WORD_MAKEATAP) begin
         queue_cmd.kind = pcd_pkg::KIND_TAP;
      end else if (word == pcd_pkg::WORD_TAKELIFT) begin
         queue_cmd.kind = pcd_pkg::KIND_LIFT;
      end else begin
         queue_cmd.kind = pcd_pkg::KIND_UNKNOWN;
      end
   end

   // Accept a transaction whenever the queue has room
   assign req_chan.ready = queue_ready;
   assign queue_push     = req_chan.valid && queue_ready;

endmodule

// File: sv/pcd_cmd_queue.sv
module pcd_cmd_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  pcd_pkg::cmd_type push_cmd,
   output logic             push_ready,
   output logic             head_valid,
   input  logic             pop,
   output pcd_pkg::cmd_type head_cmd
);

   pcd_pkg::cmd_type                  entry_ff [pcd_pkg::QUEUE_DEPTH];
   logic [pcd_pkg::QUEUE_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [pcd_pkg::QUEUE_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [pcd_pkg::QUEUE_CNT_W-1:0]   count_ff, count_in;
   logic                              do_pop;

   function automatic logic [pcd_pkg::QUEUE_PTR_W-1:0] next_ptr(
      input logic [pcd_pkg::QUEUE_PTR_W-1:0] p);
      if (p == pcd_pkg::QUEUE_PTR_W'(pcd_pkg::QUEUE_DEPTH - 1)) begin
         return '0;
      end
      return p + pcd_pkg::QUEUE_PTR_W'(1);
   endfunction

   assign push_ready = count_ff != pcd_pkg::QUEUE_CNT_W'(pcd_pkg::QUEUE_DEPTH);
   assign head_valid = count_ff != '0;
   assign do_pop     = pop && (count_ff != '0);
   assign head_cmd   = entry_ff[rd_ptr_ff];

   // Advance pointers and count
   always_comb begin
      wr_ptr_in = (push && push_ready) ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = do_pop ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if ((push && push_ready) && !do_pop) begin
         count_in = count_ff + pcd_pkg::QUEUE_CNT_W'(1);
      end else if (!(push && push_ready) && do_pop) begin
         count_in = count_ff - pcd_pkg::QUEUE_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store pushed commands
   always_ff @(posedge clock) begin
      if (push && push_ready) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= pcd_pkg::QUEUE_CNT_W'(pcd_pkg::QUEUE_DEPTH))
      else $error("queue count past depth");

   a_count_track: assert property (@(posedge clock) disable iff (reset)
      (push && push_ready && !do_pop) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("queue count missed a push");

   a_ptrs_meet_empty: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("queue pointers apart while empty");

endmodule

// File: sv/pcd_back.sv
module pcd_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             head_valid,
   input  pcd_pkg::cmd_type head_cmd,
   output logic             pop,
   pcd_rsp_if.source        rsp_chan
);

   pcd_pkg::coord_type   pos_x_ff, pos_x_in;
   pcd_pkg::coord_type   pos_y_ff, pos_y_in;
   logic                 pen_ff, pen_in;
   logic                 rsp_valid_ff;
   pcd_pkg::status_type  status_ff, status_in;
   logic                 x_inc_ff, x_inc_in;
   logic                 y_inc_ff, y_inc_in;
   pcd_pkg::coord_type   x_steps_ff, x_steps_in;
   pcd_pkg::coord_type   y_steps_ff, y_steps_in;
   logic                 tap_ff, tap_in;
   logic                 home_ff, home_in;
   logic                 x_up;
   logic                 y_up;
   pcd_pkg::coord_type   x_diff;
   pcd_pkg::coord_type   y_diff;

   // Take the head whenever the output register is free or draining
   assign pop = head_valid && (!rsp_valid_ff || rsp_chan.ready);

   // Distance from the held position
   assign x_up   = head_cmd.new_x > pos_x_ff;
   assign y_up   = head_cmd.new_y > pos_y_ff;
   assign x_diff = x_up ? head_cmd.new_x - pos_x_ff : pos_x_ff - head_cmd.new_x;
   assign y_diff = y_up ? head_cmd.new_y - pos_y_ff : pos_y_ff - head_cmd.new_y;

   // Execute the command
   always_comb begin
      pos_x_in   = pos_x_ff;
      pos_y_in   = pos_y_ff;
      pen_in     = pen_ff;
      status_in  = pcd_pkg::STATUS_DONE;
      x_inc_in   = 1'b0;
      y_inc_in   = 1'b0;
      x_steps_in = '0;
      y_steps_in = '0;
      tap_in     = 1'b0;
      home_in    = 1'b0;
      unique case (head_cmd.kind)
         pcd_pkg::KIND_MOVE: begin
            x_inc_in   = x_up;
            y_inc_in   = y_up;
            x_steps_in = x_diff;
            y_steps_in = y_diff;
            pos_x_in   = head_cmd.new_x;
            pos_y_in   = head_cmd.new_y;
         end
         pcd_pkg::KIND_BAD_COORD: begin
            status_in = pcd_pkg::STATUS_BAD_COORD;
         end
         pcd_pkg::KIND_HOME: begin
            pos_x_in = '0;
            pos_y_in = '0;
            home_in  = 1'b1;
         end
         pcd_pkg::KIND_TOUCH: begin
            pen_in = 1'b1;
         end
         pcd_pkg::KIND_TAP: begin
            pen_in = 1'b0;
            tap_in = 1'b1;
         end
         pcd_pkg::KIND_LIFT: begin
            pen_in = 1'b0;
         end
         default: begin
            status_in = pcd_pkg::STATUS_UNKNOWN;
         end
      endcase
   end

   // Hold state and the result register
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_x_ff     <= '0;
         pos_y_ff     <= '0;
         pen_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (pop) begin
            pos_x_ff     <= pos_x_in;
            pos_y_ff     <= pos_y_in;
            pen_ff       <= pen_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         status_ff  <= status_in;
         x_inc_ff   <= x_inc_in;
         y_inc_ff   <= y_inc_in;
         x_steps_ff <= x_steps_in;
         y_steps_ff <= y_steps_in;
         tap_ff     <= tap_in;
         home_ff    <= home_in;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.status       = status_ff;
   assign rsp_chan.x_increasing = x_inc_ff;
   assign rsp_chan.x_steps      = x_steps_ff;
   assign rsp_chan.y_increasing = y_inc_ff;
   assign rsp_chan.y_steps      = y_steps_ff;
   assign rsp_chan.pen_down     = pen_ff;
   assign rsp_chan.tap_request  = tap_ff;
   assign rsp_chan.home_request = home_ff;

   a_home_clears_pos: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && home_ff) |-> (pos_x_ff == '0 && pos_y_ff == '0 &&
                                     x_steps_ff == '0 && y_steps_ff == '0))
      else $error("home result with position or steps left");

   a_tap_lifts_pen: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && tap_ff) |-> (!pen_ff && !home_ff))
      else $error("tap result with pen down or home raised");

   a_error_keeps_state: assert property (@(posedge clock) disable iff (reset)
      (pop && head_cmd.kind != pcd_pkg::KIND_MOVE && head_cmd.kind != pcd_pkg::KIND_HOME)
      |=> (pos_x_ff == $past(pos_x_ff) && pos_y_ff == $past(pos_y_ff)))
      else $error("position moved on a non-move command");

endmodule

// File: sv/plotter_command_decoder_core.sv
// Plotter command decoder.
// req_chan carries one eight-character ASCII command per transaction,
// char0 first; rsp_chan returns exactly one result per command, in order.
// Both channels use valid/ready; a transaction moves on a rising clock edge
// with both high.
// The front end classifies a command in the cycle it is accepted and writes
// it into a two-entry command queue. The back end takes the queue head,
// updates the held X/Y position and pen level, and loads the result
// register; a command passes through a queue entry and then the result
// register before its result shows on rsp_chan.
// Throughput is one command per cycle while the receiver keeps ready high:
// the back end works on one queue entry per cycle and the result register
// is reloaded on the same edge it is taken.
// When the receiver stalls, the result register holds, the queue fills,
// and req_chan.ready drops once both queue entries are taken; it rises
// again in the cycle after the receiver takes a result.
// A synchronous reset empties the queue and the result register, sets the
// position to 0,0 and lifts the pen.
module plotter_command_decoder_core (
   input  logic      clock,
   input  logic      reset,
   pcd_req_if.sink   req_chan,
   pcd_rsp_if.source rsp_chan
);

   logic             push;
   logic             push_ready;
   logic             pop;
   logic             head_valid;
   pcd_pkg::cmd_type push_cmd;
   pcd_pkg::cmd_type head_cmd;

   pcd_front u_front (
      .req_chan    (req_chan),
      .queue_ready (push_ready),
      .queue_push  (push),
      .queue_cmd   (push_cmd)
   );

   pcd_cmd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_cmd   (push_cmd),
      .push_ready (push_ready),
      .head_valid (head_valid),
      .pop        (pop),
      .head_cmd   (head_cmd)
   );

   pcd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_cmd   (head_cmd),
      .pop        (pop),
      .rsp_chan   (rsp_chan)
   );

endmodule

// File: verif/tb.sv
`timescale 1ns / 100ps

module tb;

   localparam int unsigned CYCLE_LIMIT   = 200000;
   localparam int unsigned PHASE_ITEMS   = 350;
   localparam int unsigned SETTLE_CYCLES = 10;
   localparam int unsigned MAX_COORD     = 299;

   localparam logic [63:0] COMMAND_WORDS [4] = '{
      pcd_pkg::WORD_GOTOHOME, pcd_pkg::WORD_STCTOUCH,
      pcd_pkg::WORD_MAKEATAP, pcd_pkg::WORD_TAKELIFT
   };

   // Fields of one decoder result, in the order the response channel shows them
   typedef struct packed {
      pcd_pkg::status_type status;
      logic                x_increasing;
      logic [8:0]          x_steps;
      logic                y_increasing;
      logic [8:0]          y_steps;
      logic                pen_down;
      logic                tap_request;
      logic                home_request;
   } plot_result_type;

   logic clock;
   logic reset;

   pcd_req_if req_chan ();
   pcd_rsp_if rsp_chan ();

   plotter_command_decoder_core dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // Plotter state as the decoder should hold it
   logic [8:0] held_x;
   logic [8:0] held_y;
   logic       held_pen;

   plot_result_type owed_results[$];

   int unsigned send_idle_pct;
   int unsigned recv_stall_pct;
   int unsigned cycle_count;
   int unsigned error_count;
   int unsigned sent_count;
   int unsigned checked_count;
   int unsigned move_count;
   int unsigned bad_coord_count;
   int unsigned unknown_count;
   int unsigned fixed_word_count;

   initial begin
      clock = 1'b0;
   end

   always #10 clock = ~clock;

   // Print and count one mismatch
   task automatic report_error(string msg);
      error_count++;
      $display("[%0t] mismatch: %s", $realtime, msg);
   endtask

   task automatic check_field(string field, logic [8:0] got, logic [8:0] want);
      if (got !== want) begin
         report_error($sformatf("result %0d %s got %0d want %0d",
                                checked_count, field, got, want));
      end
   endtask

   function automatic bit digit_ok(logic [7:0] c, logic [7:0] hi);
      return c >= pcd_pkg::CHAR_ZERO && c <= hi;
   endfunction

   function automatic int coord_value(logic [7:0] h, logic [7:0] t, logic [7:0] u);
      return int'(h - pcd_pkg::CHAR_ZERO) * 100
           + int'(t - pcd_pkg::CHAR_ZERO) * 10
           + int'(u - pcd_pkg::CHAR_ZERO);
   endfunction

   // Decode one command against the held state and advance that state
   function automatic plot_result_type decode_command(logic [63:0] cmd);
      logic [7:0]      ch [8];
      plot_result_type r;
      int              new_x;
      int              new_y;
      int              i;
      for (i = 0; i < 8; i++) begin
         ch[i] = cmd[63 - 8 * i -: 8];
      end
      r = '0;
      r.status = pcd_pkg::STATUS_DONE;
      if (ch[0] == pcd_pkg::CHAR_C) begin
         if (digit_ok(ch[1], pcd_pkg::CHAR_TWO) && digit_ok(ch[2], pcd_pkg::CHAR_NINE) &&
             digit_ok(ch[3], pcd_pkg::CHAR_NINE) && ch[4] == pcd_pkg::CHAR_COMMA &&
             digit_ok(ch[5], pcd_pkg::CHAR_TWO) && digit_ok(ch[6], pcd_pkg::CHAR_NINE) &&
             digit_ok(ch[7], pcd_pkg::CHAR_NINE)) begin
            new_x = coord_value(ch[1], ch[2], ch[3]);
            new_y = coord_value(ch[5], ch[6], ch[7]);
            r.x_increasing = new_x > int'(held_x);
            r.x_steps = r.x_increasing ? 9'(new_x - int'(held_x)) : 9'(int'(held_x) - new_x);
            r.y_increasing = new_y > int'(held_y);
            r.y_steps = r.y_increasing ? 9'(new_y - int'(held_y)) : 9'(int'(held_y) - new_y);
            held_x = 9'(new_x);
            held_y = 9'(new_y);
            move_count++;
         end else begin
            r.status = pcd_pkg::STATUS_BAD_COORD;
            bad_coord_count++;
         end
      end else if (cmd == pcd_pkg::WORD_GOTOHOME) begin
         held_x = '0;
         held_y = '0;
         r.home_request = 1'b1;
         fixed_word_count++;
      end else if (cmd == pcd_pkg::WORD_STCTOUCH) begin
         held_pen = 1'b1;
         fixed_word_count++;
      end else if (cmd == pcd_pkg::WORD_MAKEATAP) begin
         held_pen = 1'b0;
         r.tap_request = 1'b1;
         fixed_word_count++;
      end else if (cmd == pcd_pkg::WORD_TAKELIFT) begin
         held_pen = 1'b0;
         fixed_word_count++;
      end else begin
         r.status = pcd_pkg::STATUS_UNKNOWN;
         unknown_count++;
      end
      r.pen_down = held_pen;
      return r;
   endfunction

   function automatic logic [63:0] move_word(int x, int y);
      return {pcd_pkg::CHAR_C, 8'(pcd_pkg::CHAR_ZERO + x / 100),
              8'(pcd_pkg::CHAR_ZERO + x / 10 % 10), 8'(pcd_pkg::CHAR_ZERO + x % 10),
              pcd_pkg::CHAR_COMMA, 8'(pcd_pkg::CHAR_ZERO + y / 100),
              8'(pcd_pkg::CHAR_ZERO + y / 10 % 10), 8'(pcd_pkg::CHAR_ZERO + y % 10)};
   endfunction

   // Favor the range ends and the held value so zero-step axes show up often
   function automatic int pick_coord(int current);
      int roll;
      roll = $urandom_range(9);
      if (roll == 0) begin
         return 0;
      end else if (roll == 1) begin
         return MAX_COORD;
      end else if (roll == 2) begin
         return current;
      end
      return $urandom_range(MAX_COORD);
   endfunction

   // Well-formed moves most often, then fixed words, corrupted moves and words, raw bytes
   function automatic logic [63:0] random_command();
      int          pick;
      int          pos;
      int          flip;
      logic [7:0]  hi;
      logic [7:0]  bad;
      logic [63:0] w;
      pick = $urandom_range(99);
      if (pick < 45) begin
         return move_word(pick_coord(held_x), pick_coord(held_y));
      end else if (pick < 60) begin
         w = move_word($urandom_range(MAX_COORD), $urandom_range(MAX_COORD));
         pos = $urandom_range(1, 7);
         if (pos == 4) begin
            do begin
               bad = 8'($urandom_range(255));
            end while (bad == pcd_pkg::CHAR_COMMA);
         end else begin
            hi = (pos == 1 || pos == 5) ? pcd_pkg::CHAR_TWO : pcd_pkg::CHAR_NINE;
            bad = $urandom_range(1) ? 8'($urandom_range(pcd_pkg::CHAR_ZERO - 1))
                                    : 8'($urandom_range(255, hi + 1));
         end
         w[63 - 8 * pos -: 8] = bad;
         return w;
      end else if (pick < 80) begin
         return COMMAND_WORDS[$urandom_range(3)];
      end else if (pick < 92) begin
         w = COMMAND_WORDS[$urandom_range(3)];
         flip = $urandom_range(63);
         w[flip] = ~w[flip];
         return w;
      end
      return {$urandom, $urandom};
   endfunction

   // Drive one command and hold it until accepted; leave valid high afterward
   task automatic send_command(logic [63:0] cmd);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid <= 1'b1;
      {req_chan.char0, req_chan.char1, req_chan.char2, req_chan.char3,
       req_chan.char4, req_chan.char5, req_chan.char6, req_chan.char7} <= cmd;
      do begin
         @(posedge clock);
      end while (req_chan.ready !== 1'b1);
      owed_results.push_back(decode_command(cmd));
      sent_count++;
   endtask

   // Hold off the sender until every owed result has come back
   task automatic drain_results();
      @(negedge clock);
      req_chan.valid <= 1'b0;
      while (owed_results.size() != 0) begin
         @(posedge clock);
      end
   endtask

   task automatic test_moves();
      send_command(move_word(0, 0));
      send_command(move_word(MAX_COORD, MAX_COORD));
      send_command(move_word(MAX_COORD, 0));
      send_command(move_word(0, 150));
      send_command(move_word(123, 45));
   endtask

   task automatic test_pen_and_home();
      send_command(pcd_pkg::WORD_STCTOUCH);
      send_command(move_word(10, 20));
      send_command(pcd_pkg::WORD_TAKELIFT);
      send_command(pcd_pkg::WORD_STCTOUCH);
      send_command(pcd_pkg::WORD_MAKEATAP);
      send_command(move_word(200, 200));
      send_command(pcd_pkg::WORD_GOTOHOME);
      send_command(move_word(0, 0));
   endtask

   // Errors with the pen down, so pen_down must stay high through them
   task automatic test_malformed();
      send_command(pcd_pkg::WORD_STCTOUCH);
      send_command("C300,000");
      send_command("C000,300");
      send_command("C0/0,000");
      send_command("C0:0,000");
      send_command("C000.000");
      send_command("C000,00:");
      send_command("c100,100");
      send_command("GOTOHOMF");
      send_command(64'h0);
      send_command({64{1'b1}});
   endtask

   task automatic test_random_traffic();
      int unsigned sender_pct [4];
      int unsigned receiver_pct [4];
      int          phase;
      int unsigned n;
      sender_pct   = '{0, 51, 0, 11};
      receiver_pct = '{0, 0, 51, 11};
      for (phase = 0; phase < 4; phase++) begin
         send_idle_pct  = sender_pct[phase];
         recv_stall_pct = receiver_pct[phase];
         for (n = 0; n < PHASE_ITEMS; n++) begin
            send_command(random_command());
         end
         drain_results();
      end
   endtask

   // Receiver: stall at the configured rate, changing ready on the falling edge
   always @(negedge clock) begin
      rsp_chan.ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // Compare each result transaction with the oldest owed result
   always @(posedge clock) begin : check_results
      plot_result_type want;
      if (!reset && rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
         if (owed_results.size() == 0) begin
            report_error($sformatf("result %0d arrived with none owed", checked_count));
         end else begin
            want = owed_results.pop_front();
            check_field("status",       rsp_chan.status,       want.status);
            check_field("x_increasing", rsp_chan.x_increasing, want.x_increasing);
            check_field("x_steps",      rsp_chan.x_steps,      want.x_steps);
            check_field("y_increasing", rsp_chan.y_increasing, want.y_increasing);
            check_field("y_steps",      rsp_chan.y_steps,      want.y_steps);
            check_field("pen_down",     rsp_chan.pen_down,     want.pen_down);
            check_field("tap_request",  rsp_chan.tap_request,  want.tap_request);
            check_field("home_request", rsp_chan.home_request, want.home_request);
         end
         checked_count++;
      end
   end

   // Watchdog: end the run if it hangs
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   initial begin
      reset          = 1'b1;
      req_chan.valid = 1'b0;
      {req_chan.char0, req_chan.char1, req_chan.char2, req_chan.char3,
       req_chan.char4, req_chan.char5, req_chan.char6, req_chan.char7} = '0;
      rsp_chan.ready = 1'b0;
      held_x         = '0;
      held_y         = '0;
      held_pen       = 1'b0;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      cycle_count    = 0;
      error_count    = 0;
      sent_count     = 0;
      checked_count  = 0;
      move_count     = 0;
      bad_coord_count  = 0;
      unknown_count    = 0;
      fixed_word_count = 0;

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_moves();
      test_pen_and_home();
      test_malformed();
      drain_results();
      test_random_traffic();

      // Let any stray result surface before the final tally
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (owed_results.size() != 0) begin
         report_error($sformatf("%0d results never arrived", owed_results.size()));
      end

      $display("Sent %0d commands: %0d moves, %0d bad coordinates, %0d unknown, %0d fixed",
               sent_count, move_count, bad_coord_count, unknown_count, fixed_word_count);
      $display("Checked %0d results under four idle/stall mixes, %0d mismatches",
               checked_count, error_count);
      if (error_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

// File: files.f
sv/pcd_pkg.sv
sv/pcd_req_if.sv
sv/pcd_rsp_if.sv
sv/pcd_front.sv
sv/pcd_cmd_queue.sv
sv/pcd_back.sv
sv/plotter_command_decoder_core.sv
verif/tb.sv
